// File: rtl/nff_pkg.sv
// ----------------------------------------------------------------------------
// nff_pkg
// shared types, codes and sizes of the flood forwarder
// ----------------------------------------------------------------------------
package nff_pkg;

    localparam int SEEN_ENTRIES = 16;
    localparam int QUEUE_DEPTH  = 16;
    localparam int SIW = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ID_WRAP_LIMIT = 8'd240;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_RECV  = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_DELIVER = 2'd0,
        RES_TX      = 2'd1,
        RES_DROP    = 2'd2,
        RES_NONE    = 2'd3
    } res_kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX = 2'd1;

    typedef struct packed {
        logic [15:0] orig;
        logic [7:0]  id;
        logic [7:0]  ttl;
        logic [7:0]  hops;
        logic [7:0]  retx;
        logic [7:0]  tag;
    } queue_entry_t;

endpackage

// File: rtl/nhop_flood_forwarder_top.sv
// ----------------------------------------------------------------------------
// nhop_flood_forwarder_top
// controlled flooding with duplicate suppression and a forward queue
// ----------------------------------------------------------------------------
// a receive scans the whole seen table and then decides; a duplicate with more hops
//   walks the queued entries before its result; other stale copies give no result
// a queued local send and a tick without transmit give no result; a transmit does
// throughput: one item at a time, s_tready only in idle; the next transfer can come
//   in the cycle after the result is loaded; a held result stalls
// reset (aresetn low, synchronous) clears seen valid bits, queue pointers,
//   the local id counter and the output register; own_address 0, max_retx 3
module nhop_flood_forwarder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // originator, pkt_id, pkt_hops, pkt_ttl, payload_tag, radio_ok, zero fill
    input  logic [nff_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [1:0]                        s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_originator, out_id, out_hops, prev_hops, out_ttl, out_tag
    output logic [nff_pkg::OUT_DATA_W-1:0]    m_tdata,
    // result_kind
    output logic [1:0]                        m_tuser,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [nff_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [nff_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import nff_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_DECIDE  = 6'b000100,
        ST_REWRITE = 6'b001000,
        ST_EXEC    = 6'b010000,
        ST_PUSH    = 6'b100000
    } state_t;

    // wrap an index sum into the queue range
    function automatic logic [QIW-1:0] q_wrap(input logic [QIW:0] s);
        logic [QIW:0] r;
        r = (s >= (QIW+1)'(QUEUE_DEPTH)) ? s - (QIW+1)'(QUEUE_DEPTH) : s;
        return r[QIW-1:0];
    endfunction

    // control and configuration
    state_t            state_reg, state_next;
    logic [15:0]       own_addr_reg;
    logic [7:0]        max_retx_reg;
    logic [QIW-1:0]    head_reg, head_next;
    logic [QCW-1:0]    count_reg, count_next;
    logic [7:0]        local_id_reg, local_id_next;

    // latched input item
    logic [1:0]        kind_reg;
    logic [15:0]       orig_reg;
    logic [7:0]        id_reg, hops_reg, ttl_reg, tag_reg;
    logic              ok_reg;

    // scan results
    logic [SIW-1:0]    scan_idx_reg, scan_idx_next;
    logic              found_reg, found_next, free_reg, free_next;
    logic [SIW-1:0]    found_idx_reg, found_idx_next, free_idx_reg, free_idx_next;
    logic [7:0]        e_id_reg, e_id_next, e_hops_reg, e_hops_next;
    logic [QCW-1:0]    rw_n_reg, rw_n_next;

    // pending result and output register
    logic [1:0]              pend_kind_reg, pend_kind_next;
    logic [OUT_DATA_W-1:0]   pend_data_reg, pend_data_next;
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_kind_reg, m_kind_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;

    // seen table: valid bits in flops, the rest plain storage
    logic [SEEN_ENTRIES-1:0] seen_valid_reg;
    logic [15:0]             seen_addr [SEEN_ENTRIES];
    logic [7:0]              seen_id   [SEEN_ENTRIES];
    logic [7:0]              seen_hops [SEEN_ENTRIES];

    // forward queue, undefined until written
    queue_entry_t            fwd_q [QUEUE_DEPTH];

    // storage write ports
    logic              sw_en;
    logic [SIW-1:0]    sw_idx;
    logic [7:0]        sw_hops;
    logic              qw_en;
    logic [QIW-1:0]    qw_idx;
    queue_entry_t      qw_data;

    // shared queue read port
    logic [QIW-1:0]    q_rd_idx;
    queue_entry_t      q_rd;
    logic [QIW-1:0]    tail_idx, rw_idx;

    // helpers
    logic              fresh, q_full, hdr_hit;
    logic [7:0]        d_hops, retx_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;

    assign tail_idx = q_wrap({1'b0, head_reg} + {1'b0, count_reg[QIW-1:0]});
    assign rw_idx   = q_wrap({1'b0, head_reg} + {1'b0, rw_n_reg[QIW-1:0]});
    assign q_rd_idx = (state_reg == ST_REWRITE) ? rw_idx : head_reg;
    assign q_rd     = fwd_q[q_rd_idx];
    assign q_full   = (count_reg >= QCW'(QUEUE_DEPTH));
    assign fresh    = !found_reg || (e_id_reg < id_reg) ||
                      (id_reg == 8'd0 && e_id_reg > ID_WRAP_LIMIT);
    assign hdr_hit  = (q_rd.orig == orig_reg) && (q_rd.id == e_id_reg);
    assign d_hops   = q_rd.hops - hops_reg;
    assign retx_new = (ok_reg && q_rd.retx != 8'hFF) ? q_rd.retx + 8'd1 : q_rd.retx;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        local_id_next  = local_id_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        found_idx_next = found_idx_reg;
        free_idx_next  = free_idx_reg;
        e_id_next      = e_id_reg;
        e_hops_next    = e_hops_reg;
        rw_n_next      = rw_n_reg;
        pend_kind_next = pend_kind_reg;
        pend_data_next = pend_data_reg;
        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_data_next    = m_data_reg;
        sw_en          = 1'b0;
        sw_idx         = found_idx_reg;
        sw_hops        = hops_reg;
        qw_en          = 1'b0;
        qw_idx         = tail_idx;
        qw_data        = '{orig: orig_reg, id: id_reg, ttl: ttl_reg, hops: hops_reg,
                           retx: 8'd0, tag: tag_reg};

        // output register drains independently of the sequencer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    state_next    = (s_tuser == KIND_RECV) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                // one seen entry a cycle: first match and first free slot
                if (seen_valid_reg[scan_idx_reg]) begin
                    if (!found_reg && seen_addr[scan_idx_reg] == orig_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = scan_idx_reg;
                        e_id_next      = seen_id[scan_idx_reg];
                        e_hops_next    = seen_hops[scan_idx_reg];
                    end
                end else if (!free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = scan_idx_reg;
                end
                if (scan_idx_reg == SIW'(SEEN_ENTRIES - 1)) begin
                    state_next = ST_DECIDE;
                end else begin
                    scan_idx_next = scan_idx_reg + SIW'(1);
                end
            end
            ST_DECIDE: begin
                pend_data_next = {tag_reg, 8'd0, 8'd0, 8'd0, id_reg, orig_reg};
                state_next     = ST_IDLE;
                if (!found_reg && !free_reg) begin
                    pend_kind_next = RES_DROP;
                    state_next     = ST_PUSH;
                end else if (fresh) begin
                    if (ttl_reg != 8'd0 && q_full) begin
                        pend_kind_next = RES_DROP;
                    end else begin
                        sw_en  = 1'b1;
                        sw_idx = found_reg ? found_idx_reg : free_idx_reg;
                        if (ttl_reg != 8'd0) begin
                            qw_en      = 1'b1;
                            count_next = count_reg + QCW'(1);
                        end
                        pend_kind_next = RES_DELIVER;
                        pend_data_next = {tag_reg, 8'd0, 8'd0, hops_reg, id_reg, orig_reg};
                    end
                    state_next = ST_PUSH;
                end else if (e_id_reg == id_reg && e_hops_reg < hops_reg) begin
                    rw_n_next  = '0;
                    state_next = ST_REWRITE;
                end
            end
            ST_REWRITE: begin
                // walk the queued entries one a cycle, rewriting the copies of this packet
                if (rw_n_reg == count_reg) begin
                    sw_en          = 1'b1;
                    sw_idx         = found_idx_reg;
                    pend_kind_next = RES_DELIVER;
                    pend_data_next = {tag_reg, 8'd0, e_hops_reg, hops_reg, id_reg, orig_reg};
                    state_next     = ST_PUSH;
                end else begin
                    if (hdr_hit) begin
                        qw_en        = 1'b1;
                        qw_idx       = rw_idx;
                        qw_data      = q_rd;
                        qw_data.hops = hops_reg;
                        qw_data.ttl  = (d_hops > q_rd.ttl) ? 8'd0 : q_rd.ttl - d_hops;
                    end
                    rw_n_next = rw_n_reg + QCW'(1);
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                if (kind_reg == KIND_LOCAL && ttl_reg != 8'd0) begin
                    if (q_full) begin
                        pend_kind_next = RES_DROP;
                        pend_data_next = {tag_reg, 24'd0, local_id_reg, own_addr_reg};
                        state_next     = ST_PUSH;
                    end else begin
                        qw_en         = 1'b1;
                        qw_data       = '{orig: own_addr_reg, id: local_id_reg,
                                          ttl: ttl_reg, hops: 8'd0, retx: 8'd0,
                                          tag: tag_reg};
                        count_next    = count_reg + QCW'(1);
                        local_id_next = local_id_reg + 8'd1;
                    end
                end else if (kind_reg == KIND_TICK && count_reg != '0) begin
                    if (q_rd.ttl != 8'd0) begin
                        qw_en          = 1'b1;
                        qw_idx         = head_reg;
                        qw_data        = q_rd;
                        qw_data.retx   = retx_new;
                        pend_kind_next = RES_TX;
                        pend_data_next = {q_rd.tag, q_rd.ttl - 8'd1, 8'd0,
                                          q_rd.hops + 8'd1, q_rd.id, q_rd.orig};
                        state_next     = ST_PUSH;
                    end
                    if (retx_new >= max_retx_reg || q_rd.ttl == 8'd0) begin
                        head_next  = q_wrap({1'b0, head_reg} + (QIW+1)'(1));
                        count_next = count_reg - QCW'(1);
                    end
                end
            end
            ST_PUSH: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_data_next  = pend_data_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            own_addr_reg   <= 16'd0;
            max_retx_reg   <= 8'd3;
            head_reg       <= '0;
            count_reg      <= '0;
            local_id_reg   <= 8'd0;
            m_valid_reg    <= 1'b0;
            seen_valid_reg <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            local_id_reg <= local_id_next;
            m_valid_reg  <= m_valid_next;
            if (sw_en) begin
                seen_valid_reg[sw_idx] <= 1'b1;
            end
            if (cfg_we) begin
                if (cfg_addr == CFG_OWN_ADDR) begin
                    own_addr_reg <= cfg_wdata;
                end else if (cfg_addr == CFG_MAX_RETX) begin
                    max_retx_reg <= cfg_wdata[7:0];
                end
            end
        end
    end

    // payload, scan registers and storage
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            orig_reg <= s_tdata[15:0];
            id_reg   <= s_tdata[23:16];
            hops_reg <= s_tdata[31:24];
            ttl_reg  <= s_tdata[39:32];
            tag_reg  <= s_tdata[47:40];
            ok_reg   <= s_tdata[48];
        end
        scan_idx_reg  <= scan_idx_next;
        found_reg     <= found_next;
        free_reg      <= free_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        e_id_reg      <= e_id_next;
        e_hops_reg    <= e_hops_next;
        rw_n_reg      <= rw_n_next;
        pend_kind_reg <= pend_kind_next;
        pend_data_reg <= pend_data_next;
        m_kind_reg    <= m_kind_next;
        m_data_reg    <= m_data_next;
        if (sw_en) begin
            seen_addr[sw_idx] <= orig_reg;
            seen_id[sw_idx]   <= id_reg;
            seen_hops[sw_idx] <= sw_hops;
        end
        if (qw_en) begin
            fwd_q[qw_idx] <= qw_data;
        end
    end

endmodule

// File: rtl/nff_checker.sv
// ----------------------------------------------------------------------------
// nff_checker
// port-level checks of the flood forwarder
// ----------------------------------------------------------------------------
module nff_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [nff_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [1:0]                        m_tuser
);
    import nff_pkg::*;

    // a held result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: ready falls after each transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // only defined result codes
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != RES_NONE)
        else $error("bad result kind");

    // only a re-delivery carries previous hops, only a transmit carries ttl
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != RES_TX |-> m_tdata[47:40] == 8'd0 &&
        (m_tuser == RES_DELIVER || m_tdata[39:32] == 8'd0))
        else $error("stray hop or ttl field");

endmodule

bind nhop_flood_forwarder_top nff_checker u_nff_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
